// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mar_pkg.sv =====
// ----------------------------------------------------------------------------
// mar_pkg
// Shared widths, defaults and result type of the moving-average RMS block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mar_pkg;

    localparam int ADC_W     = 8;
    localparam int WSUM_W    = 11;
    localparam int RMS_W     = 15;
    localparam int ACC_W     = 45;
    localparam int FRAC_BITS = 8;
    // Root of the scaled mean square, padded to an even number of radicand bits.
    localparam int ROOT_W    = (ACC_W + FRAC_BITS + 1) / 2;
    localparam int DATA_W    = 2 * ROOT_W;

    localparam int WINDOW_TAPS_DEF = 5;
    localparam int COUNT_BITS_DEF  = 24;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    typedef struct packed {
        logic              done;
        logic [WSUM_W-1:0] window_sum;
        logic [RMS_W-1:0]  rms_q4;
    } mar_res_t;

endpackage

// ===== hw/rtl/moving_average_running_rms.sv =====
// ----------------------------------------------------------------------------
// moving_average_running_rms
// Moving-average window sum with running RMS of the sum in Q4.
// ----------------------------------------------------------------------------
//   channel  dir  ports                               role
//   s_       in   s_valid s_ready s_adc_sample        converter sample beat
//   m_       out  m_valid m_ready m_window_sum        window sum and RMS beat
//                 m_rms_q4
//
// A sample goes through square, accumulate, 54 one-bit divide steps and 27
// root steps; the divide and root steps share one compare/subtract unit.
// s_ready is high only while the sequencer is idle; a finished beat waits in the output register,
// so the next sample is taken while m_ready is low, but the beat after it waits in the sequencer.
// Reset (aresetn low, synchronous) clears the sample history, accumulator
// and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module moving_average_running_rms #(
    parameter int WINDOW_TAPS = mar_pkg::WINDOW_TAPS_DEF,
    parameter int COUNT_BITS  = mar_pkg::COUNT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mar_pkg::ADC_W-1:0]   s_adc_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mar_pkg::WSUM_W-1:0]  m_window_sum,
    output logic [mar_pkg::RMS_W-1:0]   m_rms_q4
);
    import mar_pkg::*;

    localparam int SUM_W = ADC_W + $clog2(WINDOW_TAPS);

    logic             accept;
    logic             core_idle;
    logic [SUM_W-1:0] win_sum;
    mar_res_t         core_res;
    logic             out_load;

    logic              m_valid_reg, m_valid_next;
    logic [WSUM_W-1:0] m_window_sum_reg;
    logic [RMS_W-1:0]  m_rms_q4_reg;

    assign s_ready = core_idle;
    assign accept  = s_valid & s_ready;

    mar_window #(
        .WINDOW_TAPS (WINDOW_TAPS)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (accept),
        .sample   (s_adc_sample),
        .sum_out  (win_sum)
    );

    mar_core #(
        .SUM_W      (SUM_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .sum_in  (win_sum),
        .ack     (out_load),
        .idle    (core_idle),
        .res     (core_res)
    );

    // advance the result into the output register when it is empty or draining
    assign out_load = core_res.done & (~m_valid_reg | m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_window_sum_reg <= core_res.window_sum;
            m_rms_q4_reg     <= core_res.rms_q4;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_window_sum = m_window_sum_reg;
    assign m_rms_q4     = m_rms_q4_reg;

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    `ASSERT_NEXT(a_done_held, aclk, aresetn, core_res.done && !out_load, core_res.done, "result dropped")

endmodule

// ===== hw/rtl/mar_window.sv =====
// ----------------------------------------------------------------------------
// mar_window
// Sample history shift line with a running sum of the stored taps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mar_window #(
    parameter int WINDOW_TAPS = mar_pkg::WINDOW_TAPS_DEF
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               shift_en,
    input  logic [mar_pkg::ADC_W-1:0]                          sample,
    output logic [mar_pkg::ADC_W+$clog2(WINDOW_TAPS)-1:0]      sum_out
);
    import mar_pkg::*;

    localparam int HIST_LEN = WINDOW_TAPS - 1;
    localparam int SUM_W    = ADC_W + $clog2(WINDOW_TAPS);

    logic [ADC_W-1:0] hist_reg  [HIST_LEN];
    logic [ADC_W-1:0] hist_next [HIST_LEN];
    logic [SUM_W-1:0] hist_sum_reg, hist_sum_next;

    assign sum_out = SUM_W'(sample) + hist_sum_reg;

    always_comb begin
        hist_next     = hist_reg;
        hist_sum_next = hist_sum_reg;
        if (shift_en) begin
            for (int i = 0; i < HIST_LEN - 1; i++) begin
                hist_next[i] = hist_reg[i + 1];
            end
            hist_next[HIST_LEN-1] = sample;
            // drop the oldest tap from the running sum
            hist_sum_next = sum_out - SUM_W'(hist_reg[0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_LEN; i++) begin
                hist_reg[i] <= '0;
            end
            hist_sum_reg <= '0;
        end else begin
            hist_reg     <= hist_next;
            hist_sum_reg <= hist_sum_next;
        end
    end

endmodule

// ===== hw/rtl/mar_cmpsub.sv =====
// ----------------------------------------------------------------------------
// mar_cmpsub
// Shared compare and subtract unit used by the divide and root steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mar_cmpsub #(
    parameter int WIDTH = 34
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             ge
);
    logic [WIDTH:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[WIDTH-1:0];
    assign ge   = ~full[WIDTH];

endmodule

// ===== hw/rtl/mar_core.sv =====
// ----------------------------------------------------------------------------
// mar_core
// Sequencer: square, accumulate, bit-serial divide by count, bit-serial root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mar_core #(
    parameter int SUM_W      = 11,
    parameter int COUNT_BITS = mar_pkg::COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  sum_in,
    input  logic              ack,
    output logic              idle,
    output mar_pkg::mar_res_t res
);
    import mar_pkg::*;

    localparam int ALU_W     = (COUNT_BITS + 1 > ROOT_W + 3) ? COUNT_BITS + 1 : ROOT_W + 3;
    localparam int REM_W     = ALU_W - 1;
    localparam int SQ_W      = 2 * SUM_W;
    localparam int STEP_W    = $clog2(DATA_W);
    localparam int DIV_LAST  = DATA_W - 1;
    localparam int SQRT_LAST = ROOT_W - 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [DATA_W-1:0]     data_reg, data_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    logic [ACC_W:0]        acc_sum;
    logic [COUNT_BITS:0]   div_trial;
    logic [ROOT_W+2:0]     sqrt_trial;
    logic [ROOT_W+1:0]     sqrt_div;
    logic [ALU_W-1:0]      alu_a, alu_b, alu_diff;
    logic                  alu_ge;
    logic                  qbit;

    assign acc_sum    = {1'b0, acc_reg} + (ACC_W + 1)'(sq_reg);
    assign div_trial  = {rem_reg[COUNT_BITS-1:0], data_reg[DATA_W-1]};
    assign sqrt_trial = {rem_reg[ROOT_W:0], data_reg[DATA_W-1 -: 2]};
    assign sqrt_div   = {root_reg, 2'b01};

    always_comb begin
        if (state_reg == ST_SQRT) begin
            alu_a = ALU_W'(sqrt_trial);
            alu_b = ALU_W'(sqrt_div);
        end else begin
            alu_a = ALU_W'(div_trial);
            alu_b = ALU_W'(count_reg);
        end
    end

    mar_cmpsub #(
        .WIDTH (ALU_W)
    ) u_cmpsub (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    // a zero count yields a zero quotient
    assign qbit = alu_ge & (count_reg != '0);

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        data_next  = data_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    sum_next   = sum_in;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                sq_next    = sum_reg * sum_reg;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // hold accumulation once the count has saturated
                if (count_reg != '1) begin
                    acc_next   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
                    count_next = count_reg + 1'b1;
                end
                data_next  = DATA_W'({acc_next, {FRAC_BITS{1'b0}}});
                rem_next   = '0;
                step_next  = STEP_W'(DIV_LAST);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (qbit) begin
                    rem_next = REM_W'(alu_diff[COUNT_BITS-1:0]);
                end else begin
                    rem_next = REM_W'(div_trial[COUNT_BITS-1:0]);
                end
                data_next = {data_reg[DATA_W-2:0], qbit};
                if (step_reg == '0) begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(SQRT_LAST);
                    state_next = ST_SQRT;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_SQRT: begin
                if (alu_ge) begin
                    rem_next  = REM_W'(alu_diff[ROOT_W:0]);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = REM_W'(sqrt_trial[ROOT_W:0]);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                data_next = {data_reg[DATA_W-3:0], 2'b00};
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        sq_reg   <= sq_next;
        data_reg <= data_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
    end

    assign idle           = (state_reg == ST_IDLE);
    assign res.done       = (state_reg == ST_DONE);
    assign res.window_sum = WSUM_W'(sum_reg);
    assign res.rms_q4     = root_reg[RMS_W-1:0];

    `ASSERT_IMPL(a_start_idle, aclk, aresetn, start, state_reg == ST_IDLE, "start while busy")
    `ASSERT_IMPL(a_count_nz, aclk, aresetn, state_reg == ST_DONE, count_reg != '0, "zero count at result")
    `ASSERT_IMPL(a_root_rem, aclk, aresetn, state_reg == ST_SQRT, rem_reg[REM_W-1:ROOT_W+1] == '0, "root remainder overflow")

endmodule

// ===== dv/moving_average_running_rms_test.sv =====
// ----------------------------------------------------------------------------
// moving_average_running_rms_test
// Self-checking bench for the moving-average running RMS block. A directed
// table of samples (extremes, window fill and drain, bit patterns) is sent
// first. Random sample runs follow under four pacing modes on both channels.
// Every result beat is checked against a typed value or a bit-exact predictor
// of the window sum and the Q4 running RMS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moving_average_running_rms_test;

    localparam int CNT_BITS    = mar_pkg::COUNT_BITS_DEF;
    localparam int HIST_LEN    = mar_pkg::WINDOW_TAPS_DEF - 1;
    localparam int WSUM_W      = mar_pkg::WSUM_W;
    localparam int RMS_W       = mar_pkg::RMS_W;
    localparam bit [63:0] CNT_TOP = (64'd1 << CNT_BITS) - 64'd1;
    localparam bit [63:0] ACC_TOP = (64'd1 << mar_pkg::ACC_W) - 64'd1;
    localparam int RAND_ITEMS  = 470;
    localparam int N_DIRECTED  = 22;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int SND_IDLE [4] = '{0, 54, 0, 36};
    localparam int RCV_IDLE [4] = '{0, 0, 54, 36};

    typedef struct {
        bit [WSUM_W-1:0] sum;
        bit [RMS_W-1:0]  rms;
    } rms_beat_t;

    typedef struct {
        bit [mar_pkg::ADC_W-1:0] smp;
        bit                      typed;
        bit [WSUM_W-1:0]         sum;
        bit [RMS_W-1:0]          rms;
    } dir_row_t;

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        s_valid      = 1'b0;
    logic [mar_pkg::ADC_W-1:0]   s_adc_sample = '0;
    logic                        m_ready      = 1'b0;
    logic                        s_ready;
    logic                        m_valid;
    logic [WSUM_W-1:0]           m_window_sum;
    logic [RMS_W-1:0]            m_rms_q4;

    // Predictor state
    bit [mar_pkg::ADC_W-1:0] hist [HIST_LEN];
    bit [63:0]               sq_acc  = '0;
    bit [63:0]               smp_cnt = '0;

    rms_beat_t rms_expect_q [$];
    rms_beat_t want;
    int        mism_cnt   = 0;
    int        quiet_cnt  = 0;
    int        stall_left = 0;
    int        snd_pct    = 0;
    int        rcv_pct    = 0;

    // Only the first row after reset is typed in; the rest go through the predictor.
    dir_row_t dir_tbl [N_DIRECTED] = '{
        '{8'd0,   1'b1, 11'd0, 15'd0},
        '{8'd255, 1'b0, 11'd0, 15'd0},
        '{8'd255, 1'b0, 11'd0, 15'd0},
        '{8'd255, 1'b0, 11'd0, 15'd0},
        '{8'd255, 1'b0, 11'd0, 15'd0},
        '{8'd255, 1'b0, 11'd0, 15'd0},
        '{8'd255, 1'b0, 11'd0, 15'd0},
        '{8'd0,   1'b0, 11'd0, 15'd0},
        '{8'd0,   1'b0, 11'd0, 15'd0},
        '{8'd0,   1'b0, 11'd0, 15'd0},
        '{8'd0,   1'b0, 11'd0, 15'd0},
        '{8'd0,   1'b0, 11'd0, 15'd0},
        '{8'd1,   1'b0, 11'd0, 15'd0},
        '{8'd128, 1'b0, 11'd0, 15'd0},
        '{8'd127, 1'b0, 11'd0, 15'd0},
        '{8'd254, 1'b0, 11'd0, 15'd0},
        '{8'd85,  1'b0, 11'd0, 15'd0},
        '{8'd170, 1'b0, 11'd0, 15'd0},
        '{8'd255, 1'b0, 11'd0, 15'd0},
        '{8'd0,   1'b0, 11'd0, 15'd0},
        '{8'd15,  1'b0, 11'd0, 15'd0},
        '{8'd240, 1'b0, 11'd0, 15'd0}
    };

    moving_average_running_rms #(
        .WINDOW_TAPS (mar_pkg::WINDOW_TAPS_DEF),
        .COUNT_BITS  (CNT_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_window_sum (m_window_sum),
        .m_rms_q4     (m_rms_q4)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] root;
        bit [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic rms_beat_t advance_filter(bit [mar_pkg::ADC_W-1:0] smp);
        bit [63:0] sum;
        bit [63:0] sq;
        bit [63:0] mean;
        bit [63:0] root;
        rms_beat_t r;
        sum = 64'(smp);
        for (int i = 0; i < HIST_LEN; i++) sum += 64'(hist[i]);
        for (int i = 0; i < HIST_LEN - 1; i++) hist[i] = hist[i + 1];
        hist[HIST_LEN - 1] = smp;
        // Hold accumulator and count once the count is full.
        if (smp_cnt < CNT_TOP) begin
            sq = sum * sum;
            if (sq_acc > ACC_TOP - sq) sq_acc = ACC_TOP;
            else sq_acc += sq;
            smp_cnt++;
        end
        mean = (smp_cnt != 0) ? (sq_acc << 8) / smp_cnt : 64'd0;
        root = int_sqrt(mean);
        r.sum = sum[WSUM_W-1:0];
        r.rms = root[RMS_W-1:0];
        return r;
    endfunction

    task automatic send_sample(bit [mar_pkg::ADC_W-1:0] smp, bit typed, rms_beat_t typed_beat);
        int        gap;
        rms_beat_t beat;
        if (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_adc_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        beat = advance_filter(smp);
        rms_expect_q.push_back(typed ? typed_beat : beat);
    endtask

    // Receiver pacing: short and long stalls mixed.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (aresetn && rcv_pct != 0 && $urandom_range(99) < rcv_pct) begin
            stall_left = ($urandom_range(3) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rms_expect_q.size() == 0) begin
                $error("result beat with nothing expected: window_sum %0d rms_q4 %0d",
                       m_window_sum, m_rms_q4);
                mism_cnt++;
            end else begin
                want = rms_expect_q.pop_front();
                if (m_window_sum !== want.sum) begin
                    $error("window_sum: expected %0d, actual %0d", want.sum, m_window_sum);
                    mism_cnt++;
                end
                if (m_rms_q4 !== want.rms) begin
                    $error("rms_q4: expected %0d, actual %0d", want.rms, m_rms_q4);
                    mism_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cnt = 0;
        else quiet_cnt++;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        rms_beat_t typed_beat;
        int        mode;
        int        level;
        int        tmp;
        bit [7:0]  smp;
        for (int i = 0; i < HIST_LEN; i++) hist[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < 4; p++) begin
            snd_pct = SND_IDLE[p];
            rcv_pct = RCV_IDLE[p];
            if (p == 0) begin
                for (int r = 0; r < N_DIRECTED; r++) begin
                    typed_beat.sum = dir_tbl[r].sum;
                    typed_beat.rms = dir_tbl[r].rms;
                    send_sample(dir_tbl[r].smp, dir_tbl[r].typed, typed_beat);
                end
            end
            mode  = 0;
            level = 0;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                // Pick a new signal shape every 16 samples.
                if (n % 16 == 0) begin
                    mode  = $urandom_range(3);
                    level = $urandom_range(255);
                end
                case (mode)
                    0: smp = 8'($urandom_range(255));
                    1: smp = $urandom_range(1) ? 8'd255 : 8'd0;
                    2: begin
                        tmp = level + int'($urandom_range(6)) - 3;
                        if (tmp < 0) tmp = 0;
                        if (tmp > 255) tmp = 255;
                        smp = 8'(tmp);
                    end
                    default: smp = 8'(level + n * 17);
                endcase
                send_sample(smp, 1'b0, typed_beat);
            end
            s_valid <= 1'b0;
            while (rms_expect_q.size() != 0) @(posedge aclk);
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mism_cnt == 0 && rms_expect_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
